/* src/xylmi_pkg.sv */
// ----------------------------------------------------------------------------
// xylmi_pkg
// Shared widths, codes and types for the two-axis linear move interpolator.
// ----------------------------------------------------------------------------
package xylmi_pkg;

    localparam int POS_BITS   = 24;
    localparam int FRAC_BITS  = 16;
    localparam int ACC_BITS   = 40;
    localparam int RATE_BITS  = 16;
    localparam int TICK_BITS  = 32;
    localparam int DIFF_BITS  = POS_BITS + 1;
    localparam int SQ_BITS    = 2 * DIFF_BITS;
    localparam int ROOT_BITS  = DIFF_BITS;
    localparam int PROD_BITS  = RATE_BITS + ROOT_BITS;
    localparam int SNUM_BITS  = DIFF_BITS + FRAC_BITS;
    localparam int NUM_BITS   = (PROD_BITS > SNUM_BITS) ? PROD_BITS : SNUM_BITS;
    localparam int SQRT_STEPS = ROOT_BITS;
    localparam int DIV_STEPS  = NUM_BITS;
    localparam int CNT_BITS   = 6;
    localparam int CFG_IDX_BITS = 2;

    localparam logic [RATE_BITS-1:0] RATE_RESET = RATE_BITS'(500);

    localparam logic [CFG_IDX_BITS-1:0] CFG_FEEDRATE  = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] CFG_TICK_RATE = CFG_IDX_BITS'(1);
    localparam logic [CFG_IDX_BITS-1:0] CFG_RELATIVE  = CFG_IDX_BITS'(2);

    typedef enum logic [3:0] {
        S_IDLE, S_SQX, S_SQY, S_SQRT, S_MUL, S_DINIT_T, S_DIV_T,
        S_DINIT_X, S_DIV_X, S_DINIT_Y, S_DIV_Y, S_FIN, S_RESP
    } state_t;

    typedef enum logic [3:0] {
        DP_NONE, DP_ITEM, DP_SQX, DP_SQY, DP_SQRT, DP_MUL, DP_DINIT_T,
        DP_DIV, DP_DINIT_X, DP_DINIT_Y, DP_FIN, DP_RESP
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic busy;
        logic out_free;
        logic move_start;
    } dp_sts_t;

endpackage

/* src/xylmi_ctrl.sv */
// ----------------------------------------------------------------------------
// xylmi_ctrl
// Sequencer for request handling, square root and the shared divider.
// ----------------------------------------------------------------------------
module xylmi_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  xylmi_pkg::dp_sts_t  sts,
    output xylmi_pkg::dp_cmd_t  cmd,
    output logic                in_stall
);

    xylmi_pkg::state_t state_reg, state_next;
    logic [xylmi_pkg::CNT_BITS-1:0] cnt_reg, cnt_next;
    logic accept;
    logic cnt_zero;

    assign in_stall = !((state_reg == xylmi_pkg::S_IDLE) && sts.out_free);
    assign accept   = in_valid && !in_stall;
    assign cnt_zero = (cnt_reg == '0);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            xylmi_pkg::S_IDLE:    if (accept && sts.move_start) state_next = xylmi_pkg::S_SQX;
            xylmi_pkg::S_SQX:     state_next = xylmi_pkg::S_SQY;
            xylmi_pkg::S_SQY:     state_next = xylmi_pkg::S_SQRT;
            xylmi_pkg::S_SQRT:    if (cnt_zero) state_next = xylmi_pkg::S_MUL;
            xylmi_pkg::S_MUL:     state_next = xylmi_pkg::S_DINIT_T;
            xylmi_pkg::S_DINIT_T: state_next = xylmi_pkg::S_DIV_T;
            xylmi_pkg::S_DIV_T:   if (cnt_zero) state_next = xylmi_pkg::S_DINIT_X;
            xylmi_pkg::S_DINIT_X: state_next = xylmi_pkg::S_DIV_X;
            xylmi_pkg::S_DIV_X:   if (cnt_zero) state_next = xylmi_pkg::S_DINIT_Y;
            xylmi_pkg::S_DINIT_Y: state_next = xylmi_pkg::S_DIV_Y;
            xylmi_pkg::S_DIV_Y:   if (cnt_zero) state_next = xylmi_pkg::S_FIN;
            xylmi_pkg::S_FIN:     state_next = xylmi_pkg::S_RESP;
            xylmi_pkg::S_RESP:    if (sts.out_free) state_next = xylmi_pkg::S_IDLE;
            default:              state_next = xylmi_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.op = xylmi_pkg::DP_NONE;
        unique case (state_reg)
            xylmi_pkg::S_IDLE:    if (accept) cmd.op = xylmi_pkg::DP_ITEM;
            xylmi_pkg::S_SQX:     cmd.op = xylmi_pkg::DP_SQX;
            xylmi_pkg::S_SQY:     cmd.op = xylmi_pkg::DP_SQY;
            xylmi_pkg::S_SQRT:    cmd.op = xylmi_pkg::DP_SQRT;
            xylmi_pkg::S_MUL:     cmd.op = xylmi_pkg::DP_MUL;
            xylmi_pkg::S_DINIT_T: cmd.op = xylmi_pkg::DP_DINIT_T;
            xylmi_pkg::S_DIV_T,
            xylmi_pkg::S_DIV_X,
            xylmi_pkg::S_DIV_Y:   cmd.op = xylmi_pkg::DP_DIV;
            xylmi_pkg::S_DINIT_X: cmd.op = xylmi_pkg::DP_DINIT_X;
            xylmi_pkg::S_DINIT_Y: cmd.op = xylmi_pkg::DP_DINIT_Y;
            xylmi_pkg::S_FIN:     cmd.op = xylmi_pkg::DP_FIN;
            xylmi_pkg::S_RESP:    if (sts.out_free) cmd.op = xylmi_pkg::DP_RESP;
            default:              cmd.op = xylmi_pkg::DP_NONE;
        endcase
    end

    // Iteration counter for the square root and the divider passes.
    always_comb
    begin
        cnt_next = cnt_reg;
        case (state_reg)
            xylmi_pkg::S_SQY:
                cnt_next = xylmi_pkg::CNT_BITS'(xylmi_pkg::SQRT_STEPS - 1);
            xylmi_pkg::S_DINIT_T, xylmi_pkg::S_DINIT_X, xylmi_pkg::S_DINIT_Y:
                cnt_next = xylmi_pkg::CNT_BITS'(xylmi_pkg::DIV_STEPS - 1);
            xylmi_pkg::S_SQRT, xylmi_pkg::S_DIV_T, xylmi_pkg::S_DIV_X, xylmi_pkg::S_DIV_Y:
                cnt_next = cnt_reg - 1'b1;
            default:
                cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= xylmi_pkg::S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

/* src/xylmi_dp.sv */
// ----------------------------------------------------------------------------
// xylmi_dp
// Datapath: configuration, move set-up arithmetic, setpoint accumulation.
// ----------------------------------------------------------------------------
module xylmi_dp (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  xylmi_pkg::dp_cmd_t                    cmd,
    output xylmi_pkg::dp_sts_t                    sts,
    input  logic                                  cfg_we,
    input  logic [xylmi_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [xylmi_pkg::RATE_BITS-1:0]       cfg_data,
    input  logic                                  req_type,
    input  logic signed [xylmi_pkg::POS_BITS-1:0] target_x,
    input  logic signed [xylmi_pkg::POS_BITS-1:0] target_y,
    input  logic signed [xylmi_pkg::POS_BITS-1:0] measured_x,
    input  logic signed [xylmi_pkg::POS_BITS-1:0] measured_y,
    input  logic                                  out_stall,
    output logic                                  out_valid,
    output logic signed [xylmi_pkg::ACC_BITS-1:0] goal_x,
    output logic signed [xylmi_pkg::ACC_BITS-1:0] goal_y,
    output logic                                  moving,
    output logic                                  move_done,
    output logic                                  move_refused
);

    localparam int AB = xylmi_pkg::ACC_BITS;
    localparam int DB = xylmi_pkg::DIFF_BITS;
    localparam int NB = xylmi_pkg::NUM_BITS;
    localparam int TB = xylmi_pkg::TICK_BITS;
    localparam int RB = xylmi_pkg::ROOT_BITS;

    logic [xylmi_pkg::RATE_BITS-1:0] feedrate_reg, tick_rate_reg;
    logic                            relative_reg;

    logic signed [AB-1:0] acc_x_reg, acc_y_reg, step_x_reg, step_y_reg;
    logic [TB-1:0]        total_reg, done_reg;
    logic                 busy_reg;

    logic signed [DB-1:0] dx_reg, dy_reg;
    logic [DB-1:0]        mag_x, mag_y, sq_op;
    logic [xylmi_pkg::SQ_BITS-1:0] sq_reg, sq_prod;
    logic [RB-1:0]        root_reg;
    logic [RB+1:0]        srem_reg, srem_shift, strial;
    logic [xylmi_pkg::PROD_BITS-1:0] prod_reg;
    logic [NB-1:0]        quo_reg;
    logic [TB:0]          drem_reg, drem_shift;
    logic [TB-1:0]        dvs_reg, ticks_sat;
    logic [xylmi_pkg::RATE_BITS-1:0] fr_eff;

    logic out_valid_reg, out_done_reg, out_refused_reg, out_moving_reg;
    logic signed [AB-1:0] out_x_reg, out_y_reg;

    logic signed [DB-1:0] dx_in, dy_in;
    logic signed [AB-1:0] acc_x_tick, acc_y_tick;
    logic tick_step, tick_fin;

    function automatic logic signed [AB-1:0] sat_add(input logic signed [AB-1:0] a,
                                                      input logic signed [AB-1:0] b);
        logic signed [AB:0] s;
        s = {a[AB-1], a} + {b[AB-1], b};
        if (s[AB] != s[AB-1])
            return s[AB] ? {1'b1, {(AB-1){1'b0}}} : {1'b0, {(AB-1){1'b1}}};
        return s[AB-1:0];
    endfunction

    function automatic logic signed [AB-1:0] make_step(input logic [NB-1:0] q,
                                                        input logic neg,
                                                        input logic zero);
        logic [NB-1:0] lim;
        logic [NB-1:0] qs;
        lim = NB'(1) << (AB - 1);
        qs  = q;
        if (zero)
            return '0;
        if (neg)
        begin
            if (qs > lim)
                qs = lim;
            return -(AB'(qs));
        end
        if (qs > lim - 1'b1)
            qs = lim - 1'b1;
        return AB'(qs);
    endfunction

    assign mag_x  = dx_reg[DB-1] ? DB'(-dx_reg) : DB'(dx_reg);
    assign mag_y  = dy_reg[DB-1] ? DB'(-dy_reg) : DB'(dy_reg);
    assign sq_op  = (cmd.op == xylmi_pkg::DP_SQX) ? mag_x : mag_y;
    assign sq_prod = sq_op * sq_op;

    assign srem_shift = {srem_reg[RB-1:0], sq_reg[xylmi_pkg::SQ_BITS-1 -: 2]};
    assign strial     = {root_reg, 2'b01};

    assign drem_shift = {drem_reg[TB-1:0], quo_reg[NB-1]};
    assign ticks_sat  = (quo_reg[NB-1:TB] != '0) ? {TB{1'b1}} : quo_reg[TB-1:0];
    assign fr_eff     = (feedrate_reg == '0) ? xylmi_pkg::RATE_BITS'(1) : feedrate_reg;

    assign dx_in = relative_reg ? DB'(target_x) : (DB'(target_x) - DB'(measured_x));
    assign dy_in = relative_reg ? DB'(target_y) : (DB'(target_y) - DB'(measured_y));

    assign tick_step  = !req_type && busy_reg && (done_reg != total_reg);
    assign tick_fin   = !req_type && busy_reg && (done_reg == total_reg);
    assign acc_x_tick = tick_step ? sat_add(acc_x_reg, step_x_reg) : acc_x_reg;
    assign acc_y_tick = tick_step ? sat_add(acc_y_reg, step_y_reg) : acc_y_reg;

    assign sts.busy       = busy_reg;
    assign sts.out_free   = !out_valid_reg || !out_stall;
    assign sts.move_start = req_type && !busy_reg;

    assign out_valid    = out_valid_reg;
    assign goal_x       = out_x_reg;
    assign goal_y       = out_y_reg;
    assign moving       = out_moving_reg;
    assign move_done    = out_done_reg;
    assign move_refused = out_refused_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            feedrate_reg  <= xylmi_pkg::RATE_RESET;
            tick_rate_reg <= xylmi_pkg::RATE_RESET;
            relative_reg  <= 1'b0;
            acc_x_reg     <= '0;
            acc_y_reg     <= '0;
            step_x_reg    <= '0;
            step_y_reg    <= '0;
            total_reg     <= '0;
            done_reg      <= '0;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    xylmi_pkg::CFG_FEEDRATE:  feedrate_reg  <= cfg_data;
                    xylmi_pkg::CFG_TICK_RATE: tick_rate_reg <= cfg_data;
                    xylmi_pkg::CFG_RELATIVE:  relative_reg  <= cfg_data[0];
                    default:                  ;
                endcase
            end
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            case (cmd.op)
                xylmi_pkg::DP_ITEM:
                begin
                    if (!(req_type && !busy_reg))
                    begin
                        out_valid_reg <= 1'b1;
                        acc_x_reg     <= acc_x_tick;
                        acc_y_reg     <= acc_y_tick;
                        if (tick_step)
                            done_reg <= done_reg + 1'b1;
                        if (tick_fin)
                            busy_reg <= 1'b0;
                    end
                end
                xylmi_pkg::DP_DINIT_X:
                    total_reg <= ticks_sat;
                xylmi_pkg::DP_DINIT_Y:
                    step_x_reg <= make_step(quo_reg, dx_reg[DB-1], total_reg == '0);
                xylmi_pkg::DP_FIN:
                begin
                    step_y_reg <= make_step(quo_reg, dy_reg[DB-1], total_reg == '0);
                    done_reg   <= '0;
                    busy_reg   <= 1'b1;
                end
                xylmi_pkg::DP_RESP:
                    out_valid_reg <= 1'b1;
                default:
                    ;
            endcase
        end
    end

    // Payload and working registers.
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            xylmi_pkg::DP_ITEM:
            begin
                dx_reg          <= dx_in;
                dy_reg          <= dy_in;
                out_x_reg       <= acc_x_tick;
                out_y_reg       <= acc_y_tick;
                out_moving_reg  <= busy_reg && !tick_fin;
                out_done_reg    <= tick_fin;
                out_refused_reg <= req_type && busy_reg;
            end
            xylmi_pkg::DP_SQX:
                sq_reg <= sq_prod;
            xylmi_pkg::DP_SQY:
            begin
                sq_reg   <= sq_reg + sq_prod;
                root_reg <= '0;
                srem_reg <= '0;
            end
            xylmi_pkg::DP_SQRT:
            begin
                sq_reg <= {sq_reg[xylmi_pkg::SQ_BITS-3:0], 2'b00};
                if (srem_shift >= strial)
                begin
                    srem_reg <= srem_shift - strial;
                    root_reg <= {root_reg[RB-2:0], 1'b1};
                end
                else
                begin
                    srem_reg <= srem_shift;
                    root_reg <= {root_reg[RB-2:0], 1'b0};
                end
            end
            xylmi_pkg::DP_MUL:
                prod_reg <= tick_rate_reg * root_reg;
            xylmi_pkg::DP_DINIT_T:
            begin
                quo_reg  <= NB'(prod_reg);
                drem_reg <= '0;
                dvs_reg  <= TB'(fr_eff);
            end
            xylmi_pkg::DP_DIV:
            begin
                if (drem_shift >= {1'b0, dvs_reg})
                begin
                    drem_reg <= drem_shift - {1'b0, dvs_reg};
                    quo_reg  <= {quo_reg[NB-2:0], 1'b1};
                end
                else
                begin
                    drem_reg <= drem_shift;
                    quo_reg  <= {quo_reg[NB-2:0], 1'b0};
                end
            end
            xylmi_pkg::DP_DINIT_X:
            begin
                quo_reg  <= NB'({mag_x, {xylmi_pkg::FRAC_BITS{1'b0}}});
                drem_reg <= '0;
                dvs_reg  <= ticks_sat;
            end
            xylmi_pkg::DP_DINIT_Y:
            begin
                quo_reg  <= NB'({mag_y, {xylmi_pkg::FRAC_BITS{1'b0}}});
                drem_reg <= '0;
            end
            xylmi_pkg::DP_RESP:
            begin
                out_x_reg       <= acc_x_reg;
                out_y_reg       <= acc_y_reg;
                out_moving_reg  <= 1'b1;
                out_done_reg    <= 1'b0;
                out_refused_reg <= 1'b0;
            end
            default:
                ;
        endcase
    end

endmodule

/* src/xy_linear_move_interpolator.sv */
// ----------------------------------------------------------------------------
// xy_linear_move_interpolator
// Two-axis straight-line move interpolator with Q.16 setpoint outputs.
// ----------------------------------------------------------------------------
//  Channel   Handshake            Payload
//  request   in_valid / in_stall  req_type, target_x/y, measured_x/y
//  result    out_valid/out_stall  goal_x/y, moving, move_done, move_refused
//  config    cfg_we               cfg_index, cfg_data
//
// A tick request, and a move request refused while a move runs, are served
// in the idle state. A move request that starts a move runs through the
// squaring of both differences on the shared multiplier, 25 square root
// iterations, the rate product, and three bit-serial divider passes.
// Reset clears all control state and restores the configuration defaults.
// A request is taken only in the idle state with the result register empty
// or draining in the same cycle, so a stalled result holds back requests.
// ----------------------------------------------------------------------------
module xy_linear_move_interpolator (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [xylmi_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [xylmi_pkg::RATE_BITS-1:0]       cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic                                  req_type,
    input  logic signed [xylmi_pkg::POS_BITS-1:0] target_x,
    input  logic signed [xylmi_pkg::POS_BITS-1:0] target_y,
    input  logic signed [xylmi_pkg::POS_BITS-1:0] measured_x,
    input  logic signed [xylmi_pkg::POS_BITS-1:0] measured_y,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [xylmi_pkg::ACC_BITS-1:0] goal_x,
    output logic signed [xylmi_pkg::ACC_BITS-1:0] goal_y,
    output logic                                  moving,
    output logic                                  move_done,
    output logic                                  move_refused
);

    // The controller sequences the move set-up; the datapath holds the configuration, move and result state.
    xylmi_pkg::dp_cmd_t cmd;
    xylmi_pkg::dp_sts_t sts;

    xylmi_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .sts      (sts),
        .cmd      (cmd),
        .in_stall (in_stall)
    );

    xylmi_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .req_type     (req_type),
        .target_x     (target_x),
        .target_y     (target_y),
        .measured_x   (measured_x),
        .measured_y   (measured_y),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .goal_x       (goal_x),
        .goal_y       (goal_y),
        .moving       (moving),
        .move_done    (move_done),
        .move_refused (move_refused)
    );

    // A completing tick always leaves the block idle.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && move_done |-> !moving)
        else $error("move_done reported while still moving");

    // A refusal only happens during a move and never with an ack.
    a_refuse_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && move_refused |-> moving && !move_done)
        else $error("move_refused reported while idle");

    // Starting a move occupies the sequencer for the following cycle.
    a_start_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && req_type && !sts.busy |=> in_stall)
        else $error("request taken during move set-up");

endmodule
